/* src/trb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package trb_pkg;

  // field widths of the transfer payloads
  localparam int ANGLE_WIDTH = 16;
  localparam int COEF_WIDTH  = 16;

  // Q30 constants
  localparam logic signed [31:0] ONE_Q30        = 32'sd1073741824;
  localparam logic signed [35:0] HALF_PI_Q30    = 36'sd1686629713;
  localparam logic signed [35:0] QUARTER_PI_Q30 = 36'sd843314856;

  // largest output magnitude, plus or minus one in Q1.(COEF_WIDTH-2)
  localparam logic signed [COEF_WIDTH-1:0] COEF_LIM = COEF_WIDTH'(1) << (COEF_WIDTH - 2);

  // rotation order codes
  localparam logic [2:0] ORD_XZY = 3'd0;
  localparam logic [2:0] ORD_XYZ = 3'd1;
  localparam logic [2:0] ORD_YXZ = 3'd2;
  localparam logic [2:0] ORD_YZX = 3'd3;
  localparam logic [2:0] ORD_ZYX = 3'd4;
  localparam logic [2:0] ORD_ZXY = 3'd5;

  // pipeline depths of the back end
  localparam int SC_LAT = 23;
  localparam int MX_LAT = 5;

  typedef logic signed [31:0] unit_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle_x;
    logic signed [ANGLE_WIDTH-1:0] angle_y;
    logic signed [ANGLE_WIDTH-1:0] angle_z;
    logic [2:0]                    rotation_order;
  } trb_in_t;

  typedef struct packed {
    trb_in_t item;
    logic    bad;
  } trb_job_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] m00;
    logic signed [COEF_WIDTH-1:0] m01;
    logic signed [COEF_WIDTH-1:0] m02;
    logic signed [COEF_WIDTH-1:0] m10;
    logic signed [COEF_WIDTH-1:0] m11;
    logic signed [COEF_WIDTH-1:0] m12;
    logic signed [COEF_WIDTH-1:0] m20;
    logic signed [COEF_WIDTH-1:0] m21;
    logic signed [COEF_WIDTH-1:0] m22;
    logic                         bad_order;
  } trb_out_t;

  // Q30 multiply, sign-magnitude with rounding half away from zero
  function automatic unit_t mul_q30(input unit_t a, input unit_t b);
    logic        neg;
    logic [30:0] ua;
    logic [30:0] ub;
    logic [61:0] p;
    logic [31:0] m;
    neg = a[31] ^ b[31];
    ua  = a[31] ? 31'(-a) : 31'(a);
    ub  = b[31] ? 31'(-b) : 31'(b);
    p   = 62'(ua) * 62'(ub);
    p   = p + (62'd1 << 29);
    m   = 32'(p >> 30);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

`default_nettype wire

/* src/trb_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module trb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  trb_pkg::trb_in_t item,
  input  logic             full,
  output logic             job_valid,
  output trb_pkg::trb_job_t job
);
  import trb_pkg::*;

  logic accept;
  logic bad;

  assign accept = start && !full;

  // order codes past the six valid orders are flagged here
  always_comb begin
    bad = !(item.rotation_order inside {[ORD_XZY:ORD_ZXY]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.item <= item;
      job.bad  <= bad;
    end
  end

endmodule

`default_nettype wire

/* src/trb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module trb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  trb_pkg::trb_job_t push_job,
  output logic              pop_valid,
  output trb_pkg::trb_job_t pop_job,
  output logic              full
);
  import trb_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  trb_job_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  // back end drains one job every cycle the queue is not empty
  assign pop_valid = (count != '0);
  assign pop_job   = slots[rd_ptr];
  // one slot kept for the job still held in the front register
  assign full      = (count >= (PW+1)'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop_valid) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* src/trb_sincos.sv */
`timescale 1ns / 1ps
`default_nettype none

module trb_sincos (
  input  logic                                  clk,
  input  logic signed [trb_pkg::ANGLE_WIDTH-1:0] angle,
  output trb_pkg::unit_t                        cos_o,
  output trb_pkg::unit_t                        sin_o
);
  import trb_pkg::*;

  localparam int SHIFT = 34 - ANGLE_WIDTH;
  localparam int NSTEP = 6;
  localparam int NPOS  = 3 * NSTEP + 1;

  localparam int unsigned COS_DIV [NSTEP]   = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [NSTEP-1] = '{110, 72, 42, 20, 6};

  // multiples of pi/2 from -4 to 5, for the quadrant count
  localparam logic signed [35:0] THRESH [10] = '{
    -36'sd6746518852, -36'sd5059889139, -36'sd3373259426, -36'sd1686629713,
    36'sd0, 36'sd1686629713, 36'sd3373259426, 36'sd5059889139,
    36'sd6746518852, 36'sd8433148565
  };

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic signed [33:0] a_scaled;
  logic signed [35:0] t_off;
  logic [3:0]         n_above;
  logic signed [33:0] a_p1;
  logic signed [3:0]  q_p1;
  logic signed [35:0] q_h;
  logic signed [35:0] r_full;
  unit_t              r_p2;
  logic [1:0]         quad_p2;

  unit_t      r_p    [NPOS];
  unit_t      r2_p   [NPOS];
  logic [1:0] quad_p [NPOS];

  unit_t tc_o [NSTEP];
  unit_t ts_o [1:NSTEP-1];

  unit_t      s_f;
  unit_t      c_f;
  logic [1:0] quad_f;

  function automatic unit_t clamp_unit(input unit_t v);
    if (v > ONE_Q30) begin
      return ONE_Q30;
    end else if (v < -ONE_Q30) begin
      return -ONE_Q30;
    end
    return v;
  endfunction

  // scale to Q30 and count the pi/2 boundaries below angle + pi/4
  assign a_scaled = 34'(angle) <<< SHIFT;
  assign t_off    = 36'(a_scaled) + QUARTER_PI_Q30;

  always_comb begin
    n_above = '0;
    for (int k = 0; k < 10; k++) begin
      if (t_off >= THRESH[k]) begin
        n_above = n_above + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_p1 <= a_scaled;
    q_p1 <= $signed(n_above - 4'd5);
  end

  // remainder after taking out the quadrant multiple
  assign q_h    = q_p1 * HALF_PI_Q30;
  assign r_full = 36'(a_p1) - q_h;

  always_ff @(posedge clk) begin
    r_p2    <= r_full[31:0];
    quad_p2 <= q_p1[1:0];
  end

  // square of the reduced angle
  always_ff @(posedge clk) begin
    r_p[0]    <= r_p2;
    r2_p[0]   <= mul_q30(r_p2, r_p2);
    quad_p[0] <= quad_p2;
  end

  // carry r, r^2 and quadrant alongside the series steps
  for (genvar j = 1; j < NPOS; j++) begin : g_carry
    always_ff @(posedge clk) begin
      r_p[j]    <= r_p[j-1];
      r2_p[j]   <= r2_p[j-1];
      quad_p[j] <= quad_p[j-1];
    end
  end

  // one series term per step: multiply, divide by reciprocal multiply, correct
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic [31:0] CDIV = 32'(COS_DIV[i]);
    localparam logic [31:0] CREC = 32'((64'd1 << 32) / 64'(COS_DIV[i]));

    unit_t       tc_in;
    unit_t       pc_a;
    logic [30:0] pc_b;
    logic [30:0] qc_b;
    logic [62:0] prod_c;
    logic [30:0] qd_c;
    logic [30:0] rem_c;
    logic [30:0] q1_c;

    if (i == 0) begin : g_first
      assign tc_in = ONE_Q30;
    end else begin : g_next
      assign tc_in = tc_o[i-1];
    end

    always_comb begin
      prod_c = 63'(pc_a[30:0]) * 63'(CREC);
      qd_c   = qc_b * 31'(CDIV);
      rem_c  = pc_b - qd_c;
      q1_c   = (rem_c >= 31'(CDIV)) ? qc_b + 31'd1 : qc_b;
    end

    always_ff @(posedge clk) begin
      pc_a    <= mul_q30(r2_p[3*i], tc_in);
      pc_b    <= pc_a[30:0];
      qc_b    <= prod_c[62:32];
      tc_o[i] <= ONE_Q30 - $signed({1'b0, q1_c});
    end

    // sine series has one term fewer and starts a step later
    if (i > 0) begin : g_sin
      localparam logic [31:0] SDIV = 32'(SIN_DIV[i-1]);
      localparam logic [31:0] SREC = 32'((64'd1 << 32) / 64'(SIN_DIV[i-1]));

      unit_t       ts_in;
      unit_t       ps_a;
      logic [30:0] ps_b;
      logic [30:0] qs_b;
      logic [62:0] prod_s;
      logic [30:0] qd_s;
      logic [30:0] rem_s;
      logic [30:0] q1_s;

      if (i == 1) begin : g_sfirst
        assign ts_in = ONE_Q30;
      end else begin : g_snext
        assign ts_in = ts_o[i-1];
      end

      always_comb begin
        prod_s = 63'(ps_a[30:0]) * 63'(SREC);
        qd_s   = qs_b * 31'(SDIV);
        rem_s  = ps_b - qd_s;
        q1_s   = (rem_s >= 31'(SDIV)) ? qs_b + 31'd1 : qs_b;
      end

      always_ff @(posedge clk) begin
        ps_a    <= mul_q30(r2_p[3*i], ts_in);
        ps_b    <= ps_a[30:0];
        qs_b    <= prod_s[62:32];
        ts_o[i] <= ONE_Q30 - $signed({1'b0, q1_s});
      end
    end
  end

  // sine needs the final multiply by r
  always_ff @(posedge clk) begin
    s_f    <= mul_q30(r_p[NPOS-1], ts_o[NSTEP-1]);
    c_f    <= tc_o[NSTEP-1];
    quad_f <= quad_p[NPOS-1];
  end

  // clamp and rotate into the quadrant
  always_ff @(posedge clk) begin
    case (quad_f)
      QUAD_0: begin
        cos_o <= clamp_unit(c_f);
        sin_o <= clamp_unit(s_f);
      end
      QUAD_1: begin
        cos_o <= -clamp_unit(s_f);
        sin_o <= clamp_unit(c_f);
      end
      QUAD_2: begin
        cos_o <= -clamp_unit(c_f);
        sin_o <= -clamp_unit(s_f);
      end
      QUAD_3: begin
        cos_o <= clamp_unit(s_f);
        sin_o <= -clamp_unit(c_f);
      end
      default: begin
        cos_o <= clamp_unit(c_f);
        sin_o <= clamp_unit(s_f);
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/trb_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none

module trb_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        order,
  input  logic              bad,
  input  trb_pkg::unit_t    cos_i [3],
  input  trb_pkg::unit_t    sin_i [3],
  output logic              out_valid,
  output trb_pkg::trb_out_t result
);
  import trb_pkg::*;

  localparam int SH = 32 - COEF_WIDTH;

  logic [1:0] idx1, idx2, idx3;

  // stage 1: slots by order
  logic       v1, bad1;
  logic [2:0] ord1;
  unit_t      c1, s1, c2, s2, c3, s3;

  // stage 2: pair products
  logic       v2, bad2;
  logic [2:0] ord2;
  unit_t      s2_2;
  unit_t      s3_2;
  unit_t      p_c2c3, p_c2s3, p_s1s3, p_c1c2, p_c3s1;
  unit_t      p_c1c3, p_c2s1, p_c1s3, p_c1s2, p_s1s2;

  // stage 3: triple products
  logic       v3, bad3;
  logic [2:0] ord3;
  unit_t      s2_3;
  unit_t      q_c2c3, q_c2s3, q_s1s3, q_c1c2, q_c3s1, q_c1c3, q_c2s1, q_c1s3;
  unit_t      t_c1c3s2, t_c1s2s3, t_c3s1s2, t_s1s2s3;

  // stage 4: sums
  logic               v4, bad4;
  logic signed [32:0] e   [9];
  logic signed [32:0] e_r [9];

  function automatic unit_t sel3(input unit_t a0, input unit_t a1, input unit_t a2,
                                 input logic [1:0] idx);
    case (idx)
      2'd0:    return a0;
      2'd1:    return a1;
      default: return a2;
    endcase
  endfunction

  function automatic logic signed [32:0] x33(input unit_t v);
    return 33'(v);
  endfunction

  // round half away from zero and saturate to plus or minus one
  function automatic logic signed [COEF_WIDTH-1:0] to_coef(input logic signed [32:0] v);
    logic [32:0]           u;
    logic [34:0]           ur;
    logic [34:0]           lim;
    logic [COEF_WIDTH-1:0] m;
    u   = v[32] ? 33'(-v) : 33'(v);
    ur  = ((35'(u) << 1) + (35'd1 << SH)) >> (SH + 1);
    lim = 35'd1 << (COEF_WIDTH - 2);
    if (ur > lim) begin
      ur = lim;
    end
    m = COEF_WIDTH'(ur);
    return v[32] ? -$signed(m) : $signed(m);
  endfunction

  // angle slots per order
  always_comb begin
    case (order)
      ORD_XZY: begin idx1 = 2'd0; idx2 = 2'd2; idx3 = 2'd1; end
      ORD_XYZ: begin idx1 = 2'd0; idx2 = 2'd1; idx3 = 2'd2; end
      ORD_YXZ: begin idx1 = 2'd1; idx2 = 2'd0; idx3 = 2'd2; end
      ORD_YZX: begin idx1 = 2'd1; idx2 = 2'd2; idx3 = 2'd0; end
      ORD_ZYX: begin idx1 = 2'd2; idx2 = 2'd1; idx3 = 2'd0; end
      ORD_ZXY: begin idx1 = 2'd2; idx2 = 2'd0; idx3 = 2'd1; end
      default: begin idx1 = 2'd0; idx2 = 2'd1; idx3 = 2'd2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    ord1 <= order;
    bad1 <= bad;
    c1   <= sel3(cos_i[0], cos_i[1], cos_i[2], idx1);
    s1   <= sel3(sin_i[0], sin_i[1], sin_i[2], idx1);
    c2   <= sel3(cos_i[0], cos_i[1], cos_i[2], idx2);
    s2   <= sel3(sin_i[0], sin_i[1], sin_i[2], idx2);
    c3   <= sel3(cos_i[0], cos_i[1], cos_i[2], idx3);
    s3   <= sel3(sin_i[0], sin_i[1], sin_i[2], idx3);
  end

  // s2 and s3 are carried to line up with the pair products
  always_ff @(posedge clk) begin
    ord2   <= ord1;
    bad2   <= bad1;
    s2_2   <= s2;
    s3_2   <= s3;
    p_c2c3 <= mul_q30(c2, c3);
    p_c2s3 <= mul_q30(c2, s3);
    p_s1s3 <= mul_q30(s1, s3);
    p_c1c2 <= mul_q30(c1, c2);
    p_c3s1 <= mul_q30(c3, s1);
    p_c1c3 <= mul_q30(c1, c3);
    p_c2s1 <= mul_q30(c2, s1);
    p_c1s3 <= mul_q30(c1, s3);
    p_c1s2 <= mul_q30(c1, s2);
    p_s1s2 <= mul_q30(s1, s2);
  end

  always_ff @(posedge clk) begin
    ord3     <= ord2;
    bad3     <= bad2;
    s2_3     <= s2_2;
    q_c2c3   <= p_c2c3;
    q_c2s3   <= p_c2s3;
    q_s1s3   <= p_s1s3;
    q_c1c2   <= p_c1c2;
    q_c3s1   <= p_c3s1;
    q_c1c3   <= p_c1c3;
    q_c2s1   <= p_c2s1;
    q_c1s3   <= p_c1s3;
    t_c1c3s2 <= mul_q30(p_c1c3, s2_2);
    t_c1s2s3 <= mul_q30(p_c1s2, s3_2);
    t_c3s1s2 <= mul_q30(p_c3s1, s2_2);
    t_s1s2s3 <= mul_q30(p_s1s2, s3_2);
  end

  // entries per order, exact sums in Q30
  always_comb begin
    case (ord3)
      ORD_XZY: begin
        e[0] = x33(q_c2c3);
        e[1] = -x33(s2_3);
        e[2] = x33(q_c2s3);
        e[3] = x33(q_s1s3) + x33(t_c1c3s2);
        e[4] = x33(q_c1c2);
        e[5] = x33(t_c1s2s3) - x33(q_c3s1);
        e[6] = x33(t_c3s1s2) - x33(q_c1s3);
        e[7] = x33(q_c2s1);
        e[8] = x33(q_c1c3) + x33(t_s1s2s3);
      end
      ORD_XYZ: begin
        e[0] = x33(q_c2c3);
        e[1] = -x33(q_c2s3);
        e[2] = x33(s2_3);
        e[3] = x33(q_c1s3) + x33(t_c3s1s2);
        e[4] = x33(q_c1c3) - x33(t_s1s2s3);
        e[5] = -x33(q_c2s1);
        e[6] = x33(q_s1s3) - x33(t_c1c3s2);
        e[7] = x33(q_c3s1) + x33(t_c1s2s3);
        e[8] = x33(q_c1c2);
      end
      ORD_YXZ: begin
        e[0] = x33(q_c1c3) + x33(t_s1s2s3);
        e[1] = x33(t_c3s1s2) - x33(q_c1s3);
        e[2] = x33(q_c2s1);
        e[3] = x33(q_c2s3);
        e[4] = x33(q_c2c3);
        e[5] = -x33(s2_3);
        e[6] = x33(t_c1s2s3) - x33(q_c3s1);
        e[7] = x33(t_c1c3s2) + x33(q_s1s3);
        e[8] = x33(q_c1c2);
      end
      ORD_YZX: begin
        e[0] = x33(q_c1c2);
        e[1] = x33(q_s1s3) - x33(t_c1c3s2);
        e[2] = x33(q_c3s1) + x33(t_c1s2s3);
        e[3] = x33(s2_3);
        e[4] = x33(q_c2c3);
        e[5] = -x33(q_c2s3);
        e[6] = -x33(q_c2s1);
        e[7] = x33(q_c1s3) + x33(t_c3s1s2);
        e[8] = x33(q_c1c3) - x33(t_s1s2s3);
      end
      ORD_ZYX: begin
        e[0] = x33(q_c1c2);
        e[1] = x33(t_c1s2s3) - x33(q_c3s1);
        e[2] = x33(q_s1s3) + x33(t_c1c3s2);
        e[3] = x33(q_c2s1);
        e[4] = x33(q_c1c3) + x33(t_s1s2s3);
        e[5] = x33(t_c3s1s2) - x33(q_c1s3);
        e[6] = -x33(s2_3);
        e[7] = x33(q_c2s3);
        e[8] = x33(q_c2c3);
      end
      ORD_ZXY: begin
        e[0] = x33(q_c1c3) - x33(t_s1s2s3);
        e[1] = -x33(q_c2s1);
        e[2] = x33(q_c1s3) + x33(t_c3s1s2);
        e[3] = x33(q_c3s1) + x33(t_c1s2s3);
        e[4] = x33(q_c1c2);
        e[5] = x33(q_s1s3) - x33(t_c1c3s2);
        e[6] = -x33(q_c2s3);
        e[7] = x33(s2_3);
        e[8] = x33(q_c2c3);
      end
      default: begin
        for (int k = 0; k < 9; k++) begin
          e[k] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bad4 <= bad3;
    for (int k = 0; k < 9; k++) begin
      e_r[k] <= e[k];
    end
  end

  // output rounding, zero entries on a bad order
  always_ff @(posedge clk) begin
    result.m00       <= bad4 ? '0 : to_coef(e_r[0]);
    result.m01       <= bad4 ? '0 : to_coef(e_r[1]);
    result.m02       <= bad4 ? '0 : to_coef(e_r[2]);
    result.m10       <= bad4 ? '0 : to_coef(e_r[3]);
    result.m11       <= bad4 ? '0 : to_coef(e_r[4]);
    result.m12       <= bad4 ? '0 : to_coef(e_r[5]);
    result.m20       <= bad4 ? '0 : to_coef(e_r[6]);
    result.m21       <= bad4 ? '0 : to_coef(e_r[7]);
    result.m22       <= bad4 ? '0 : to_coef(e_r[8]);
    result.bad_order <= bad4;
  end

endmodule

`default_nettype wire

/* src/tait_bryan_rotation_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tait-Bryan rotation matrix from three Q4.12 angles and an order code, nine Q1.14
// entries out. A transfer is taken on any cycle with start high and busy low, one
// per clock; each result comes out on result with done high for one cycle, in
// order. The path runs through the front end register and the queue slot, then the
// sine/cosine pipeline: range reduction and squaring, six series steps of three
// stages each (multiply, reciprocal multiply, correction) with the cosine and sine
// terms side by side, and the final multiply and quadrant rotation; then the
// five-stage matrix product and rounding pipeline. The receiver cannot stall; since
// the back end drains its input queue every cycle, busy is high only during reset.
// Order codes 6 and 7 return bad_order with all entries zero.
module tait_bryan_rotation_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  trb_pkg::trb_in_t  item,
  output logic              busy,
  output logic              done,
  output trb_pkg::trb_out_t result
);
  import trb_pkg::*;

  localparam int TOTAL_LAT = SC_LAT + MX_LAT + 2;

  logic     full;
  logic     job_valid;
  trb_job_t job;
  logic     q_valid;
  trb_job_t q_job;

  logic signed [ANGLE_WIDTH-1:0] angles [3];
  unit_t cos_v [3];
  unit_t sin_v [3];

  logic       vld_d [SC_LAT];
  logic [2:0] ord_d [SC_LAT];
  logic       bad_d [SC_LAT];

  // no transfer is taken during reset
  assign busy = full || rst;

  // front: accept and classify
  trb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .full      (full),
    .job_valid (job_valid),
    .job       (job)
  );

  // queue between front and back
  trb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_job  (job),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .full      (full)
  );

  assign angles[0] = q_job.item.angle_x;
  assign angles[1] = q_job.item.angle_y;
  assign angles[2] = q_job.item.angle_z;

  // one sine/cosine pipeline per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    trb_sincos u_sincos (
      .clk   (clk),
      .angle (angles[a]),
      .cos_o (cos_v[a]),
      .sin_o (sin_v[a])
    );
  end

  // job tag travels beside the sine/cosine pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d[0] <= 1'b0;
    end else begin
      vld_d[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    ord_d[0] <= q_job.item.rotation_order;
    bad_d[0] <= q_job.bad;
  end

  for (genvar j = 1; j < SC_LAT; j++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[j] <= 1'b0;
      end else begin
        vld_d[j] <= vld_d[j-1];
      end
    end

    always_ff @(posedge clk) begin
      ord_d[j] <= ord_d[j-1];
      bad_d[j] <= bad_d[j-1];
    end
  end

  // matrix products and output rounding
  trb_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_d[SC_LAT-1]),
    .order     (ord_d[SC_LAT-1]),
    .bad       (bad_d[SC_LAT-1]),
    .cos_i     (cos_v),
    .sin_i     (sin_v),
    .out_valid (done),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching input transfer");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.bad_order |->
      result.m00 == '0 && result.m01 == '0 && result.m02 == '0 &&
      result.m10 == '0 && result.m11 == '0 && result.m12 == '0 &&
      result.m20 == '0 && result.m21 == '0 && result.m22 == '0)
    else $error("bad order with nonzero entries");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    done |->
      result.m00 <= COEF_LIM && result.m00 >= -COEF_LIM &&
      result.m11 <= COEF_LIM && result.m11 >= -COEF_LIM &&
      result.m22 <= COEF_LIM && result.m22 >= -COEF_LIM &&
      result.m01 <= COEF_LIM && result.m01 >= -COEF_LIM &&
      result.m12 <= COEF_LIM && result.m12 >= -COEF_LIM)
    else $error("entry outside plus or minus one");
`endif

endmodule

`default_nettype wire

/* tb/tait_bryan_rotation_matrix_tb.sv */
`timescale 1ns / 1ps

module tait_bryan_rotation_matrix_tb;
  import trb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 400;

  // fixed point helpers for the matrix predictor, Q30 in 64-bit signed
  function automatic longint qmul(input longint a, input longint b);
    bit      neg;
    longint  ua;
    longint  ub;
    longint  p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = (ua * ub + (64'sd1 <<< 29)) >>> 30;
    return neg ? -p : p;
  endfunction

  function automatic longint qmul3(input longint a, input longint b, input longint c);
    return qmul(qmul(a, b), c);
  endfunction

  function automatic longint unit_clamp(input longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // cosine and sine of one Q4.12 angle by range reduction and Taylor terms
  task automatic angle_trig(input logic signed [ANGLE_WIDTH-1:0] ang,
                            output longint co, output longint si);
    longint one;
    longint hp;
    longint a;
    longint t;
    longint q;
    longint r;
    longint r2;
    longint ts;
    longint tc;
    longint s;
    longint c;
    longint sdiv[5];
    longint cdiv[6];
    one  = 64'sd1073741824;
    hp   = 64'sd1686629713;
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    a = longint'(ang) * (64'sd1 <<< (34 - ANGLE_WIDTH));
    t = a + 64'sd843314856;
    q = t / hp;
    if ((t % hp) != 0 && t < 0) q--;
    r  = a - q * hp;
    r2 = qmul(r, r);
    ts = one;
    tc = one;
    for (int i = 0; i < 5; i++) ts = one - qmul(r2, ts) / sdiv[i];
    for (int i = 0; i < 6; i++) tc = one - qmul(r2, tc) / cdiv[i];
    s = unit_clamp(qmul(r, ts));
    c = unit_clamp(tc);
    case (((q % 4) + 4) % 4)
      0: begin co = c;  si = s;  end
      1: begin co = -s; si = c;  end
      2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endtask

  // Q30 entry to Q1.14 with rounding and saturation
  function automatic logic signed [COEF_WIDTH-1:0] to_q14(input longint v);
    bit     neg;
    longint u;
    longint lim;
    lim = 64'sd1 <<< (COEF_WIDTH - 2);
    neg = v < 0;
    u   = neg ? -v : v;
    u   = (u + (64'sd1 <<< (31 - COEF_WIDTH))) >>> (32 - COEF_WIDTH);
    if (u > lim) u = lim;
    return COEF_WIDTH'(neg ? -u : u);
  endfunction

  // predicted matrix for one input transfer
  task automatic predict_matrix(input trb_in_t it, output trb_out_t res);
    longint cs[3];
    longint sn[3];
    longint m[9];
    int     p1;
    int     p2;
    int     p3;
    longint c1, s1, c2, s2, c3, s3;
    res = '0;
    if (it.rotation_order > ORD_ZXY) begin
      res.bad_order = 1'b1;
      return;
    end
    angle_trig(it.angle_x, cs[0], sn[0]);
    angle_trig(it.angle_y, cs[1], sn[1]);
    angle_trig(it.angle_z, cs[2], sn[2]);
    case (it.rotation_order)
      ORD_XZY: begin p1 = 0; p2 = 2; p3 = 1; end
      ORD_XYZ: begin p1 = 0; p2 = 1; p3 = 2; end
      ORD_YXZ: begin p1 = 1; p2 = 0; p3 = 2; end
      ORD_YZX: begin p1 = 1; p2 = 2; p3 = 0; end
      ORD_ZYX: begin p1 = 2; p2 = 1; p3 = 0; end
      default: begin p1 = 2; p2 = 0; p3 = 1; end
    endcase
    c1 = cs[p1]; s1 = sn[p1];
    c2 = cs[p2]; s2 = sn[p2];
    c3 = cs[p3]; s3 = sn[p3];
    case (it.rotation_order)
      ORD_XZY: begin
        m[0] = qmul(c2, c3); m[1] = -s2; m[2] = qmul(c2, s3);
        m[3] = qmul(s1, s3) + qmul3(c1, c3, s2); m[4] = qmul(c1, c2);
        m[5] = qmul3(c1, s2, s3) - qmul(c3, s1);
        m[6] = qmul3(c3, s1, s2) - qmul(c1, s3); m[7] = qmul(c2, s1);
        m[8] = qmul(c1, c3) + qmul3(s1, s2, s3);
      end
      ORD_XYZ: begin
        m[0] = qmul(c2, c3); m[1] = -qmul(c2, s3); m[2] = s2;
        m[3] = qmul(c1, s3) + qmul3(c3, s1, s2);
        m[4] = qmul(c1, c3) - qmul3(s1, s2, s3); m[5] = -qmul(c2, s1);
        m[6] = qmul(s1, s3) - qmul3(c1, c3, s2);
        m[7] = qmul(c3, s1) + qmul3(c1, s2, s3); m[8] = qmul(c1, c2);
      end
      ORD_YXZ: begin
        m[0] = qmul(c1, c3) + qmul3(s1, s2, s3);
        m[1] = qmul3(c3, s1, s2) - qmul(c1, s3); m[2] = qmul(c2, s1);
        m[3] = qmul(c2, s3); m[4] = qmul(c2, c3); m[5] = -s2;
        m[6] = qmul3(c1, s2, s3) - qmul(c3, s1);
        m[7] = qmul3(c1, c3, s2) + qmul(s1, s3); m[8] = qmul(c1, c2);
      end
      ORD_YZX: begin
        m[0] = qmul(c1, c2); m[1] = qmul(s1, s3) - qmul3(c1, c3, s2);
        m[2] = qmul(c3, s1) + qmul3(c1, s2, s3);
        m[3] = s2; m[4] = qmul(c2, c3); m[5] = -qmul(c2, s3);
        m[6] = -qmul(c2, s1); m[7] = qmul(c1, s3) + qmul3(c3, s1, s2);
        m[8] = qmul(c1, c3) - qmul3(s1, s2, s3);
      end
      ORD_ZYX: begin
        m[0] = qmul(c1, c2); m[1] = qmul3(c1, s2, s3) - qmul(c3, s1);
        m[2] = qmul(s1, s3) + qmul3(c1, c3, s2);
        m[3] = qmul(c2, s1); m[4] = qmul(c1, c3) + qmul3(s1, s2, s3);
        m[5] = qmul3(c3, s1, s2) - qmul(c1, s3);
        m[6] = -s2; m[7] = qmul(c2, s3); m[8] = qmul(c2, c3);
      end
      default: begin
        m[0] = qmul(c1, c3) - qmul3(s1, s2, s3); m[1] = -qmul(c2, s1);
        m[2] = qmul(c1, s3) + qmul3(c3, s1, s2);
        m[3] = qmul(c3, s1) + qmul3(c1, s2, s3); m[4] = qmul(c1, c2);
        m[5] = qmul(s1, s3) - qmul3(c1, c3, s2);
        m[6] = -qmul(c2, s3); m[7] = s2; m[8] = qmul(c2, c3);
      end
    endcase
    res.m00 = to_q14(m[0]); res.m01 = to_q14(m[1]); res.m02 = to_q14(m[2]);
    res.m10 = to_q14(m[3]); res.m11 = to_q14(m[4]); res.m12 = to_q14(m[5]);
    res.m20 = to_q14(m[6]); res.m21 = to_q14(m[7]); res.m22 = to_q14(m[8]);
  endtask

  // queue of predicted matrices, checked in transfer order
  class matrix_scoreboard;
    trb_out_t pending[$];
    int       mismatches;
    int       matched;
    int       bad_seen;

    function new();
      mismatches = 0;
      matched    = 0;
      bad_seen   = 0;
    endfunction

    task note_input(input trb_in_t it);
      trb_out_t r;
      predict_matrix(it, r);
      pending.push_back(r);
    endtask

    function void report(input string what, input logic [15:0] e, input logic [15:0] a);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: %s expected %0d got %0d", mismatches, what,
                 $signed(e), $signed(a));
    endfunction

    function void check_result(input trb_out_t got);
      trb_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch %0d: result with none expected", mismatches);
        return;
      end
      want = pending.pop_front();
      if (want.bad_order) bad_seen++;
      if (got === want) begin
        matched++;
        return;
      end
      if (got.m00 !== want.m00) report("m00", want.m00, got.m00);
      if (got.m01 !== want.m01) report("m01", want.m01, got.m01);
      if (got.m02 !== want.m02) report("m02", want.m02, got.m02);
      if (got.m10 !== want.m10) report("m10", want.m10, got.m10);
      if (got.m11 !== want.m11) report("m11", want.m11, got.m11);
      if (got.m12 !== want.m12) report("m12", want.m12, got.m12);
      if (got.m20 !== want.m20) report("m20", want.m20, got.m20);
      if (got.m21 !== want.m21) report("m21", want.m21, got.m21);
      if (got.m22 !== want.m22) report("m22", want.m22, got.m22);
      if (got.bad_order !== want.bad_order)
        report("bad_order", 16'(want.bad_order), 16'(got.bad_order));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  trb_in_t  item = '0;
  logic     busy;
  logic     done;
  trb_out_t result;
  int       idle_cycles = 0;
  int       sent = 0;
  matrix_scoreboard board = new();

  always #2 clk = ~clk;

  tait_bryan_rotation_matrix uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  // monitor: input transfers, results and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_input(item);
        idle_cycles <= 0;
      end else if (done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (done) board.check_result(result);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", board.pending.size());
        $display("** tait_bryan_rotation_matrix: FAILED **");
        $finish;
      end
    end
  end

  // random gap, mostly short, sometimes long, often none
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    repeat (n) @(negedge clk);
  endtask

  // one transfer, start held across back-to-back items
  task automatic send_item(input trb_in_t it, input bit gaps);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
    if (gaps && ($urandom_range(0, 99) < 45)) begin
      start <= 1'b0;
      item  <= trb_in_t'({$urandom(), $urandom()});
      idle_gap();
    end
  endtask

  function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return ANGLE_WIDTH'($urandom());
    if (k < 8) return ANGLE_WIDTH'($signed($urandom_range(0, 25736)) - 12868);
    // near multiples of pi/2 in Q4.12
    return ANGLE_WIDTH'(6434 * ($signed($urandom_range(0, 10)) - 5)
                        + $signed($urandom_range(0, 6)) - 3);
  endfunction

  initial begin
    trb_in_t it;
    logic signed [ANGLE_WIDTH-1:0] edges[8];
    edges = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd6434, -16'sd6434,
              16'sd12868, 16'sd3217};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every order with extreme and quadrant-edge angles, plus invalid codes
    for (int o = 0; o < 8; o++) begin
      it.angle_x = edges[o];
      it.angle_y = edges[(o + 3) % 8];
      it.angle_z = edges[(o + 5) % 8];
      it.rotation_order = 3'(o);
      send_item(it, 1'b0);
    end
    for (int o = ORD_XZY; o <= ORD_ZXY; o++) begin
      it = '{16'sh8000, 16'sh8000, 16'sh8000, 3'(o)};
      send_item(it, 1'b0);
      it = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 3'(o)};
      send_item(it, 1'b1);
    end
    it = '{16'sh7fff, 16'sh8000, 16'sh5555, 3'd7};
    send_item(it, 1'b1);
    it = '{16'sh0000, 16'shffff, 16'shaaaa, 3'd6};
    send_item(it, 1'b1);

    // random: mostly valid orders, a few invalid codes
    repeat (RANDOM_ITEMS) begin
      it.angle_x = rand_angle();
      it.angle_y = rand_angle();
      it.angle_z = rand_angle();
      it.rotation_order = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5));
      send_item(it, $urandom_range(0, 9) < 8);
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d transfers over all six orders and invalid codes", sent);
    $display("matched %0d matrices, %0d with bad order, %0d mismatches", board.matched,
             board.bad_seen, board.mismatches);
    if (board.mismatches == 0)
      $display("** tait_bryan_rotation_matrix: PASSED **");
    else
      $display("** tait_bryan_rotation_matrix: FAILED **");
    $finish;
  end

endmodule
